// File: design/dfr_pkg.sv
// Package for the delimited frame receiver: delimiter bytes and result event codes.
// No dependencies.
`default_nettype none

package dfr_pkg;

    localparam logic [7:0] START_BYTE = 8'hFF;
    localparam logic [7:0] END_BYTE   = 8'hFE;

    typedef enum logic [1:0] {
        EV_NONE    = 2'd0,
        EV_BYTE    = 2'd1,
        EV_DONE    = 2'd2,
        EV_DISCARD = 2'd3
    } t_event;

endpackage

`default_nettype wire

// File: design/delimited_frame_receiver.sv
// Delimited frame receiver: parses 0xFF, flags, device, length, payload, 0xFE frames.
// Depends on dfr_pkg.
//
// Usage: bytes arrive on the input channel (i_valid / o_ready / i_rx_byte), one
// transfer per byte. Every accepted byte produces exactly one result transfer on
// the output channel (o_valid / i_ready): an event code (nothing, payload byte
// with index, frame done, frame discarded) plus the flags, device id and length
// of the current or last frame.
// Latency: the result of a byte is presented in the cycle after its transfer.
// Throughput: one byte per cycle while the output is not stalled; the parse state
// and the result register are updated in a single pass at each input transfer.
// Stall: the result register holds while i_ready is low; o_ready stays high
// while the register is empty or is being emptied in the same cycle, so a
// new byte can enter in the cycle its predecessor's result leaves.
// Reset (synchronous, i_rst_n low): parser waits for a start byte, header
// fields and payload count clear, no result is pending.
`default_nettype none

module delimited_frame_receiver (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [7:0] i_rx_byte,
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic [1:0]      o_event_res,
    output logic [7:0]      o_payload_byte,
    output logic [7:0]      o_payload_index,
    output logic [7:0]      o_frame_flags,
    output logic [7:0]      o_frame_device,
    output logic [7:0]      o_frame_length
);

    typedef enum logic [2:0] {
        PH_WAIT   = 3'd0,
        PH_FLAGS  = 3'd1,
        PH_DEVICE = 3'd2,
        PH_LENGTH = 3'd3,
        PH_DATA   = 3'd4,
        PH_END    = 3'd5
    } t_phase;

    t_phase          r_phase, n_phase;
    logic [7:0]      r_flags, n_flags;
    logic [7:0]      r_device, n_device;
    logic [7:0]      r_length, n_length;
    logic [7:0]      r_count, n_count;
    dfr_pkg::t_event n_event;
    logic [7:0]      n_pbyte, n_pidx;
    logic            r_valid;
    logic            w_in_xfer;

    assign o_ready   = !r_valid || i_ready;
    assign w_in_xfer = i_valid && o_ready;
    assign o_valid   = r_valid;

    always_comb begin
        n_phase  = r_phase;
        n_flags  = r_flags;
        n_device = r_device;
        n_length = r_length;
        n_count  = r_count;
        n_event  = dfr_pkg::EV_NONE;
        n_pbyte  = 8'd0;
        n_pidx   = 8'd0;
        if (r_phase != PH_WAIT && i_rx_byte == dfr_pkg::START_BYTE) begin
            n_event = dfr_pkg::EV_DISCARD;
            n_phase = PH_FLAGS;
        end else begin
            unique case (r_phase)
                PH_FLAGS: begin
                    n_flags = i_rx_byte;
                    n_phase = PH_DEVICE;
                end
                PH_DEVICE: begin
                    n_device = i_rx_byte;
                    n_phase  = PH_LENGTH;
                end
                PH_LENGTH: begin
                    n_length = i_rx_byte;
                    n_count  = 8'd0;
                    n_phase  = PH_DATA;
                end
                PH_DATA: begin
                    if (r_count != r_length) begin
                        if (i_rx_byte == dfr_pkg::END_BYTE) begin
                            n_event = dfr_pkg::EV_DISCARD;
                            n_phase = PH_WAIT;
                        end else begin
                            n_event = dfr_pkg::EV_BYTE;
                            n_pbyte = i_rx_byte;
                            n_pidx  = r_count;
                            n_count = r_count + 8'd1;
                        end
                    end else if (i_rx_byte == dfr_pkg::END_BYTE) begin
                        n_event = dfr_pkg::EV_DONE;
                        n_phase = PH_WAIT;
                    end else begin
                        n_phase = PH_END;
                    end
                end
                PH_END: begin
                    if (i_rx_byte == dfr_pkg::END_BYTE) begin
                        n_event = dfr_pkg::EV_DONE;
                        n_phase = PH_WAIT;
                    end
                end
                default: begin
                    n_phase = (i_rx_byte == dfr_pkg::START_BYTE) ? PH_FLAGS : PH_WAIT;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_WAIT;
            r_flags  <= 8'd0;
            r_device <= 8'd0;
            r_length <= 8'd0;
            r_count  <= 8'd0;
            r_valid  <= 1'b0;
        end else begin
            if (w_in_xfer) begin
                r_phase         <= n_phase;
                r_flags         <= n_flags;
                r_device        <= n_device;
                r_length        <= n_length;
                r_count         <= n_count;
                r_valid         <= 1'b1;
                o_event_res     <= n_event;
                o_payload_byte  <= n_pbyte;
                o_payload_index <= n_pidx;
                o_frame_flags   <= n_flags;
                o_frame_device  <= n_device;
                o_frame_length  <= n_length;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result pending after reset");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_DATA |-> r_count <= r_length)
        else $error("payload count beyond declared length");

    a_quiet_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_event_res != dfr_pkg::EV_BYTE)
            |-> (o_payload_byte == 8'd0 && o_payload_index == 8'd0))
        else $error("payload fields nonzero outside a payload event");

    a_idle_ignore: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_xfer && r_phase == PH_WAIT && i_rx_byte != dfr_pkg::START_BYTE)
            |=> (o_valid && o_event_res == dfr_pkg::EV_NONE && r_phase == PH_WAIT))
        else $error("byte outside a frame was not ignored");

endmodule

`default_nettype wire
